FILE: rtl/ovlt_pkg.sv
// Shared types and codes for the ordered value list table.
package ovlt_pkg;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_UPDATE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_ACT,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    step;
        logic    start_shift;
        logic    shift_wr;
        logic    wr_append;
        logic    wr_update;
        logic    inc_count;
        logic    dec_count;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic match;
        logic walk_end;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/ordered_value_list_table_core.sv
// Top level of the ordered value list table: controller plus datapath.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------
//  request  | i_in_valid / o_in_ready      | i_command, i_key, i_replacement
//  result   | o_out_valid / i_out_ready    | o_status, o_entry_count
//
// One request at a time. Search, update and delete scan, and delete then shifts the later
// entries, walking the single-port-read entry RAM one slot per cycle.
// Reset clears the count and control; the entry RAM is not cleared.
// A new request is accepted while a result waits; a stalled result holds the next one.
module ordered_value_list_table_core import ovlt_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_key,
    input  logic [31:0] i_replacement,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_entry_count
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    ovlt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    ovlt_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_command    (i_command),
        .i_key        (i_key),
        .i_replacement(i_replacement),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_entry_count(o_entry_count)
    );

endmodule

FILE: rtl/ovlt_ram.sv
// Generic simple dual-port RAM with registered read.
module ovlt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/ovlt_dp.sv
// Datapath: request registers, entry store, walk pointer, count and result register.
module ovlt_dp import ovlt_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_key,
    input  logic [31:0] i_replacement,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic [6:0]  o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_cmd          r_cmd;
    logic [31:0]   r_key;
    logic [31:0]   r_repl;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_idx;
    logic          r_pend;
    logic [AW-1:0] r_pend_addr;
    t_status       r_status;
    logic          r_out_valid;
    t_status       r_out_status;
    logic [6:0]    r_out_count;

    logic          rd_lt;
    logic          rd_en;
    logic [31:0]   rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    assign rd_lt = (r_idx < r_count);
    assign rd_en = i_cmd.step && rd_lt;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pend_addr;
        wr_data = rd_data;
        if (i_cmd.wr_append) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_data = r_key;
        end else if (i_cmd.wr_update) begin
            wr_en   = 1'b1;
            wr_addr = r_pend_addr;
            wr_data = r_repl;
        end else if (i_cmd.shift_wr && r_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_pend_addr - AW'(1);
            wr_data = rd_data;
        end
    end

    ovlt_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_idx[AW-1:0]),
        .o_rd_data(rd_data)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.inc_count) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.dec_count) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= t_cmd'(i_command);
            r_key  <= i_key;
            r_repl <= i_replacement;
            r_idx  <= '0;
        end else if (i_cmd.start_shift) begin
            r_idx <= CW'(r_pend_addr) + CW'(1);
        end else if (rd_en) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.step) begin
            r_pend_addr <= r_idx[AW-1:0];
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_count  <= 7'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load || i_cmd.start_shift) begin
                r_pend <= 1'b0;
            end else if (i_cmd.step) begin
                r_pend <= rd_lt;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.cmd      = r_cmd;
    assign o_sts.full     = (r_count == CW'(CAPACITY));
    assign o_sts.match    = r_pend && (rd_data == r_key);
    assign o_sts.walk_end = !rd_lt && !r_pend;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

endmodule

FILE: rtl/ovlt_ctrl.sv
// Controller: state machine sequencing append, scan, update and delete shift.
module ovlt_ctrl import ovlt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_APPEND: n_state = S_DONE;
            S_SCAN: begin
                if (i_sts.match) begin
                    n_state = S_ACT;
                end else if (i_sts.walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_ACT: begin
                if (i_sts.cmd == CMD_DELETE) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (i_sts.walk_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_SCAN && i_sts.cmd == CMD_APPEND) begin
            n_state = S_APPEND;
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = ST_OK;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_APPEND: begin
                o_cmd.set_status = 1'b1;
                if (i_sts.full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.wr_append = 1'b1;
                    o_cmd.inc_count = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_sts.cmd != CMD_APPEND && !i_sts.match) begin
                    if (i_sts.walk_end) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOMATCH;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_ACT: begin
                o_cmd.set_status = 1'b1;
                unique case (i_sts.cmd)
                    CMD_UPDATE: o_cmd.wr_update   = 1'b1;
                    CMD_DELETE: o_cmd.start_shift = 1'b1;
                    default:    o_cmd.set_status  = 1'b1;
                endcase
            end
            S_SHIFT: begin
                if (i_sts.walk_end) begin
                    o_cmd.dec_count = 1'b1;
                end else begin
                    o_cmd.step     = 1'b1;
                    o_cmd.shift_wr = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: test/ordered_value_list_table_core_test.sv
// Testbench for ordered_value_list_table_core: directed and random requests, list predictor.
`timescale 1ns / 100ps

module ordered_value_list_table_core_test import ovlt_pkg::*; ();

    localparam int LIST_DEPTH    = 64;
    localparam int HALF_PERIOD   = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 2500;
    localparam int TAIL_CYCLES   = 2 * LIST_DEPTH + 16;
    localparam int RANDOM_ITEMS  = 620;

    typedef struct {
        t_status    status;
        logic [6:0] count;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_command;
    logic [31:0] i_key;
    logic [31:0] i_replacement;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [6:0]  o_entry_count;

    logic [31:0] shadow_list [LIST_DEPTH];
    int          shadow_count;
    t_outcome    expected_outcomes [$];

    int mismatch_count;
    int requests_sent;
    int results_checked;
    int ok_seen;
    int nomatch_seen;
    int full_seen;
    int burst_left;
    bit hold_results;

    ordered_value_list_table_core #(
        .CAPACITY(LIST_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_replacement (i_replacement),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void predict_outcome(t_cmd cmd, logic [31:0] key, logic [31:0] repl);
        t_outcome outcome;
        int       pos;
        int       i;
        pos = -1;
        outcome.status = ST_NOMATCH;
        for (i = 0; i < shadow_count; i++) begin
            if (pos < 0 && shadow_list[i] == key) begin
                pos = i;
            end
        end
        case (cmd)
            CMD_APPEND: begin
                if (shadow_count >= LIST_DEPTH) begin
                    outcome.status = ST_FULL;
                end else begin
                    shadow_list[shadow_count] = key;
                    shadow_count++;
                    outcome.status = ST_OK;
                end
            end
            CMD_SEARCH: begin
                if (pos >= 0) begin
                    outcome.status = ST_OK;
                end
            end
            CMD_DELETE: begin
                if (pos >= 0) begin
                    for (i = pos; i < shadow_count - 1; i++) begin
                        shadow_list[i] = shadow_list[i + 1];
                    end
                    shadow_count--;
                    outcome.status = ST_OK;
                end
            end
            default: begin
                if (pos >= 0) begin
                    shadow_list[pos] = repl;
                    outcome.status = ST_OK;
                end
            end
        endcase
        outcome.count = 7'(shadow_count);
        expected_outcomes.push_back(outcome);
    endfunction

    // stored key, a one-bit near miss of one, or a fresh random value
    function automatic logic [31:0] pick_key();
        logic [31:0] stored;
        int          roll;
        roll = $urandom_range(0, 9);
        if (shadow_count == 0 || roll >= 8) begin
            return $urandom();
        end
        stored = shadow_list[$urandom_range(0, shadow_count - 1)];
        if (roll == 7) begin
            return stored ^ (32'd1 << $urandom_range(0, 31));
        end
        return stored;
    endfunction

    task automatic send_request(t_cmd cmd, logic [31:0] key, logic [31:0] repl);
        int gap;
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_key         <= key;
        i_replacement <= repl;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_outcome(cmd, key, repl);
        requests_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() > 0) @(posedge i_clk);
    endtask

    task automatic test_empty_list();
        send_request(CMD_SEARCH, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_DELETE, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(CMD_UPDATE, 32'h7FFF_FFFF, 32'h1234_5678);
    endtask

    task automatic test_extremes_and_duplicates();
        send_request(CMD_APPEND, 32'h8000_0000, 32'h0000_0000);
        send_request(CMD_APPEND, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_APPEND, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_APPEND, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(CMD_APPEND, 32'h0000_0005, 32'h0000_0000);
        send_request(CMD_APPEND, 32'h0000_0005, 32'h0000_0000);
        send_request(CMD_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(CMD_SEARCH, 32'h7FFF_FFFE, 32'h0000_0000);
        send_request(CMD_UPDATE, 32'h0000_0005, 32'hAAAA_AAAA);
        send_request(CMD_SEARCH, 32'h0000_0005, 32'h0000_0000);
        send_request(CMD_DELETE, 32'h0000_0005, 32'h0000_0000);
        send_request(CMD_SEARCH, 32'h0000_0005, 32'h0000_0000);
        send_request(CMD_DELETE, 32'h8000_0000, 32'h0000_0000);
        send_request(CMD_DELETE, 32'hAAAA_AAAA, 32'h0000_0000);
        send_request(CMD_UPDATE, 32'h0000_0000, 32'h5555_5555);
        send_request(CMD_UPDATE, 32'h1234_5678, 32'hFFFF_FFFF);
        send_request(CMD_SEARCH, 32'h5555_5555, 32'h0000_0000);
    endtask

    task automatic test_fill_to_capacity();
        int n;
        while (shadow_count < LIST_DEPTH) begin
            send_request(CMD_APPEND, pick_key(), $urandom());
        end
        for (n = 0; n < 4; n++) begin
            send_request(CMD_APPEND, $urandom(), $urandom());
        end
        send_request(CMD_SEARCH, shadow_list[LIST_DEPTH - 1], $urandom());
        send_request(CMD_UPDATE, shadow_list[LIST_DEPTH - 1], $urandom());
        send_request(CMD_DELETE, shadow_list[LIST_DEPTH - 1], $urandom());
        send_request(CMD_APPEND, $urandom(), $urandom());
        send_request(CMD_DELETE, shadow_list[0], $urandom());
        send_request(CMD_APPEND, $urandom(), $urandom());
        send_request(CMD_APPEND, $urandom(), $urandom());
        for (n = 0; n < 6; n++) begin
            send_request(t_cmd'($urandom_range(1, 3)), pick_key(), $urandom());
        end
    endtask

    task automatic test_result_backpressure();
        int n;
        hold_results = 1'b1;
        for (n = 0; n < 12; n++) begin
            send_request(t_cmd'($urandom_range(0, 3)), pick_key(), $urandom());
        end
    endtask

    // alternate growing and shrinking phases of the command mix
    task automatic test_random_mix();
        int   n;
        int   roll;
        bit   growing;
        t_cmd cmd;
        growing = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                growing = ~growing;
            end
            roll = $urandom_range(0, 99);
            if (growing) begin
                cmd = (roll < 50) ? CMD_APPEND : (roll < 70) ? CMD_SEARCH :
                      (roll < 80) ? CMD_DELETE : CMD_UPDATE;
            end else begin
                cmd = (roll < 10) ? CMD_APPEND : (roll < 30) ? CMD_SEARCH :
                      (roll < 80) ? CMD_DELETE : CMD_UPDATE;
            end
            send_request(cmd, pick_key(), $urandom());
        end
    endtask

    // result side: random runs and stalls, plus one long hold on request
    initial begin : result_sink
        int run_left;
        int stall_left;
        int hold_left;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                hold_results = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (run_left > 0) begin
                i_out_ready <= 1'b1;
                run_left--;
            end else begin
                run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
                stall_left = $urandom_range(0, 6);
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch($sformatf("result with none expected: status %0d count %0d",
                                          o_status, o_entry_count));
            end else begin
                want = expected_outcomes.pop_front();
                results_checked++;
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              results_checked, o_status, want.status));
                end
                if (o_entry_count !== want.count) begin
                    report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                              results_checked, o_entry_count, want.count));
                end
                case (want.status)
                    ST_OK:      ok_seen++;
                    ST_NOMATCH: nomatch_seen++;
                    default:    full_seen++;
                endcase
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[%0t] no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("ordered_value_list_table_core_test: FAIL");
        $finish;
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_command       = CMD_APPEND;
        i_key           = '0;
        i_replacement   = '0;
        i_out_ready     = 1'b0;
        shadow_count    = 0;
        mismatch_count  = 0;
        requests_sent   = 0;
        results_checked = 0;
        ok_seen         = 0;
        nomatch_seen    = 0;
        full_seen       = 0;
        hold_results    = 1'b0;
        burst_left      = $urandom_range(1, 24);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_extremes_and_duplicates();
        wait_for_results();
        test_fill_to_capacity();
        wait_for_results();
        test_result_backpressure();
        wait_for_results();
        test_random_mix();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d results with all four commands",
                 requests_sent, results_checked);
        $display("statuses seen: %0d done, %0d no match, %0d list full",
                 ok_seen, nomatch_seen, full_seen);
        if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
            $display("ordered_value_list_table_core_test: PASS");
        end else begin
            $display("ordered_value_list_table_core_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/ovlt_pkg.sv
rtl/ovlt_ram.sv
rtl/ovlt_dp.sv
rtl/ovlt_ctrl.sv
rtl/ordered_value_list_table_core.sv
test/ordered_value_list_table_core_test.sv
